// ----- hw/rtl/hit_merge_by_key_accumulate_macros.svh -----
// assertion helpers for the hit merger
`ifndef HIT_MERGE_BY_KEY_ACCUMULATE_MACROS_SVH
`define HIT_MERGE_BY_KEY_ACCUMULATE_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define HMK_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hmk: same-cycle check failed");

// next-cycle implication
`define HMK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hmk: next-cycle check failed");

`else

`define HMK_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define HMK_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/hmk_pkg.sv -----
package hmk_pkg;

  localparam int VIEW_W       = 2;
  localparam int COORD_W      = 8;
  localparam int CHARGE_W     = 16;
  localparam int OUT_CHARGE_W = 24;
  localparam int KEY_W        = VIEW_W + 3 * COORD_W;

  // merge key, view in the top bits
  typedef struct packed {
    logic [VIEW_W-1:0]  view;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } key_t;

endpackage

// ----- hw/rtl/hmk_in_if.sv -----
interface hmk_in_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [hmk_pkg::VIEW_W-1:0]     hit_view;
  logic [hmk_pkg::COORD_W-1:0]    hit_x;
  logic [hmk_pkg::COORD_W-1:0]    hit_y;
  logic [hmk_pkg::COORD_W-1:0]    hit_z;
  logic [hmk_pkg::CHARGE_W-1:0]   hit_charge;

  modport source (output valid, mode, hit_view, hit_x, hit_y, hit_z, hit_charge,
                  input ready);
  modport sink (input valid, mode, hit_view, hit_x, hit_y, hit_z, hit_charge,
                output ready);
endinterface

// ----- hw/rtl/hmk_out_if.sv -----
interface hmk_out_if;
  logic                             valid;
  logic                             ready;
  logic [hmk_pkg::VIEW_W-1:0]       out_view;
  logic [hmk_pkg::COORD_W-1:0]      out_x;
  logic [hmk_pkg::COORD_W-1:0]      out_y;
  logic [hmk_pkg::COORD_W-1:0]      out_z;
  logic [hmk_pkg::OUT_CHARGE_W-1:0] out_charge;
  logic                             last_entry;
  logic                             dropped_hits;

  modport source (output valid, out_view, out_x, out_y, out_z, out_charge, last_entry,
                  dropped_hits, input ready);
  modport sink (input valid, out_view, out_x, out_y, out_z, out_charge, last_entry,
                dropped_hits, output ready);
endinterface

// ----- hw/rtl/hmk_entry_ram.sv -----
module hmk_entry_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 50,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/hit_merge_by_key_accumulate.sv -----
// channel   dir  transfer carries
// --------  ---  ----------------------------------------------------------
// in_chan   in   mode, hit_view, hit_x, hit_y, hit_z, hit_charge
// out_chan  out  out_view, out_x, out_y, out_z, out_charge, last_entry,
//                dropped_hits
//
// a hit holds in_chan.ready low after its transfer while it scans the stored keys,
//   reading one stored key a cycle; a matching stored key ends the scan early
// end of event: each stored entry is read, then loaded into the output register;
//   a load waits while a loaded result still waits for out_chan.ready
// reset clears state, entry count and overflow flag; the memory is left as is
// the last result may still wait in the output register while the next item is taken
`include "hit_merge_by_key_accumulate_macros.svh"

module hit_merge_by_key_accumulate #(
  parameter int MAX_ENTRIES = 64,
  parameter int SUM_BITS    = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  hmk_in_if.sink    in_chan,
  hmk_out_if.source out_chan
);

  import hmk_pkg::*;

  localparam int IDX_W   = $clog2(MAX_ENTRIES);
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int ENTRY_W = KEY_W + SUM_BITS;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_ENTRIES);

  // controller states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  // control state
  logic [1:0]       state_r,    state_nxt;
  logic [CNT_W-1:0] count_r,    count_nxt;
  logic             overflow_r, overflow_nxt;
  logic [CNT_W-1:0] scan_r,     scan_nxt;
  logic             chk_vld_r,  chk_vld_nxt;
  logic [IDX_W-1:0] chk_idx_r,  chk_idx_nxt;
  logic [IDX_W-1:0] emit_r,     emit_nxt;
  logic             emit_dv_r,  emit_dv_nxt;
  logic             out_vld_r,  out_vld_nxt;

  // payload held for the item in flight
  key_t                key_r,    key_nxt;
  logic [CHARGE_W-1:0] charge_r, charge_nxt;

  // output register
  key_t                    out_key_r;
  logic [OUT_CHARGE_W-1:0] out_charge_r;
  logic                    out_last_r;
  logic                    out_drop_r;

  // memory port
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  key_t                    rd_key;
  logic [SUM_BITS-1:0]     rd_sum;
  logic [SUM_BITS:0]       sum_wide;
  logic [SUM_BITS-1:0]     sum_sat;
  logic [OUT_CHARGE_W-1:0] rd_charge_out;
  key_t                    in_key;
  logic                    in_xfer;
  logic                    key_match;
  logic                    scan_more;
  logic                    out_free;
  logic                    emit_load;
  logic                    emit_last;

  hmk_entry_ram #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (ENTRY_W)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_key = key_t'(ram_rdata[ENTRY_W-1 -: KEY_W]);
  assign rd_sum = ram_rdata[SUM_BITS-1:0];

  // saturating accumulate of the stored sum
  assign sum_wide = {1'b0, rd_sum} + (SUM_BITS + 1)'(charge_r);
  assign sum_sat  = sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];

  // output charge: clip wide sums, widen narrow ones
  generate
    if (SUM_BITS > OUT_CHARGE_W) begin : g_clip
      assign rd_charge_out = (|rd_sum[SUM_BITS-1:OUT_CHARGE_W]) ?
                             {OUT_CHARGE_W{1'b1}} : rd_sum[OUT_CHARGE_W-1:0];
    end else begin : g_widen
      assign rd_charge_out = OUT_CHARGE_W'(rd_sum);
    end
  endgenerate

  assign in_key.view = in_chan.hit_view;
  assign in_key.x    = in_chan.hit_x;
  assign in_key.y    = in_chan.hit_y;
  assign in_key.z    = in_chan.hit_z;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;

  // compare the entry read in the previous cycle
  assign key_match = (state_r == S_SCAN) && chk_vld_r && (rd_key == key_r);
  assign scan_more = (scan_r < count_r);

  assign out_free  = !out_vld_r || out_chan.ready;
  assign emit_load = (state_r == S_EMIT) && emit_dv_r && out_free;
  assign emit_last = ((CNT_W'(emit_r) + CNT_W'(1)) == count_r);

  // read address follows the scan pointer or the emit pointer
  assign ram_raddr = (state_r == S_SCAN) ? scan_r[IDX_W-1:0] : emit_r;

  // write back a merged sum, or place a new key at the end of the table
  assign ram_we    = (state_r == S_SCAN) &&
                     (key_match || (!scan_more && (count_r != FULL_CNT)));
  assign ram_waddr = key_match ? chk_idx_r : count_r[IDX_W-1:0];
  assign ram_wdata = key_match ? {key_r, sum_sat} : {key_r, SUM_BITS'(charge_r)};

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    overflow_nxt = overflow_r;
    scan_nxt     = scan_r;
    chk_vld_nxt  = 1'b0;
    chk_idx_nxt  = chk_idx_r;
    emit_nxt     = emit_r;
    emit_dv_nxt  = 1'b0;
    key_nxt      = key_r;
    charge_nxt   = charge_r;
    out_vld_nxt  = out_vld_r;

    if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end
    if (emit_load) begin
      out_vld_nxt = 1'b1;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_chan.mode) begin
            // end of event; an empty table gives no transfer
            if (count_r == '0) begin
              overflow_nxt = 1'b0;
            end else begin
              emit_nxt  = '0;
              state_nxt = S_EMIT;
            end
          end else begin
            key_nxt    = in_key;
            charge_nxt = in_chan.hit_charge;
            scan_nxt   = '0;
            state_nxt  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (key_match) begin
          state_nxt = S_IDLE;
        end else if (scan_more) begin
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = scan_r[IDX_W-1:0];
          scan_nxt    = scan_r + CNT_W'(1);
        end else begin
          // new key: take the next entry, or drop it when full
          if (count_r == FULL_CNT) begin
            overflow_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (emit_load) begin
          emit_nxt = emit_r + IDX_W'(1);
          if (emit_last) begin
            count_nxt    = '0;
            overflow_nxt = 1'b0;
            state_nxt    = S_IDLE;
          end
        end else begin
          // address held this cycle, data valid next cycle
          emit_dv_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      overflow_r <= 1'b0;
      scan_r     <= '0;
      chk_vld_r  <= 1'b0;
      chk_idx_r  <= '0;
      emit_r     <= '0;
      emit_dv_r  <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      overflow_r <= overflow_nxt;
      scan_r     <= scan_nxt;
      chk_vld_r  <= chk_vld_nxt;
      chk_idx_r  <= chk_idx_nxt;
      emit_r     <= emit_nxt;
      emit_dv_r  <= emit_dv_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    charge_r <= charge_nxt;
    if (emit_load) begin
      out_key_r    <= rd_key;
      out_charge_r <= rd_charge_out;
      out_last_r   <= emit_last;
      out_drop_r   <= overflow_r;
    end
  end

  assign out_chan.valid        = out_vld_r;
  assign out_chan.out_view     = out_key_r.view;
  assign out_chan.out_x        = out_key_r.x;
  assign out_chan.out_y        = out_key_r.y;
  assign out_chan.out_z        = out_key_r.z;
  assign out_chan.out_charge   = out_charge_r;
  assign out_chan.last_entry   = out_last_r;
  assign out_chan.dropped_hits = out_drop_r;

  // overflow only ever follows a full table
  `HMK_ASSERT_IMPL(a_overflow_full, clk, rst_n, overflow_r, count_r == FULL_CNT)
  // entry count stays within the table
  `HMK_ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, count_r <= FULL_CNT)
  // a compared entry is always one of the stored entries
  `HMK_ASSERT_IMPL(a_chk_stored, clk, rst_n, chk_vld_r, CNT_W'(chk_idx_r) < count_r)
  // the last emitted entry empties the table
  `HMK_ASSERT_NEXT(a_emit_clears, clk, rst_n, emit_load && emit_last,
                   count_r == '0 && !overflow_r && state_r == S_IDLE)
  // a loaded result is never overwritten before its transfer
  `HMK_ASSERT_IMPL(a_no_overwrite, clk, rst_n, emit_load && out_vld_r, out_chan.ready)

endmodule

// ----- tb/hmk_merge_checker.sv -----
module hmk_merge_checker #(
  parameter int MAX_ENTRIES = 64,
  parameter int SUM_BITS    = 24
) (
  input  logic clk,
  input  logic rst_n,
  hmk_in_if    in_mon,
  hmk_out_if   out_mon,
  output int   error_count,
  output int   pending_count,
  output int   entries_checked
);

  import hmk_pkg::*;

  localparam longint unsigned SUM_CEIL = (64'd1 << SUM_BITS) - 64'd1;
  localparam longint unsigned OUT_CEIL = (64'd1 << OUT_CHARGE_W) - 64'd1;

  typedef struct packed {
    key_t                    key;
    logic [OUT_CHARGE_W-1:0] charge;
    logic                    last_entry;
    logic                    dropped_hits;
  } merged_entry_t;

  // own copy of the key table and running sums
  key_t            table_keys [MAX_ENTRIES];
  longint unsigned table_sums [MAX_ENTRIES];
  int              n_entries;
  bit              overflow_flag;
  merged_entry_t   merged_q[$];

  task automatic absorb_hit(input key_t key, input longint unsigned charge);
    longint unsigned total;
    for (int i = 0; i < n_entries; i++) begin
      if (table_keys[i] == key) begin
        total = table_sums[i] + charge;
        table_sums[i] = (total > SUM_CEIL) ? SUM_CEIL : total;
        return;
      end
    end
    if (n_entries >= MAX_ENTRIES) begin
      overflow_flag = 1'b1;
    end else begin
      table_keys[n_entries] = key;
      table_sums[n_entries] = (charge > SUM_CEIL) ? SUM_CEIL : charge;
      n_entries++;
    end
  endtask

  // end of event: one entry per stored key, then the table empties
  task automatic flush_event();
    merged_entry_t e;
    for (int i = 0; i < n_entries; i++) begin
      e.key          = table_keys[i];
      e.charge       = OUT_CHARGE_W'((table_sums[i] > OUT_CEIL) ? OUT_CEIL : table_sums[i]);
      e.last_entry   = (i == n_entries - 1);
      e.dropped_hits = overflow_flag;
      merged_q = {merged_q, e};
    end
    n_entries     = 0;
    overflow_flag = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  task automatic check_entry();
    merged_entry_t want;
    if (merged_q.size() == 0) begin
      error_count++;
      $display("%0t: unexpected entry, expected none, got view %0h x %0h y %0h z %0h",
               $time, out_mon.out_view, out_mon.out_x, out_mon.out_y, out_mon.out_z);
      return;
    end
    want = merged_q.pop_front();
    entries_checked++;
    check_field("out_view", 32'(want.key.view), 32'(out_mon.out_view));
    check_field("out_x", 32'(want.key.x), 32'(out_mon.out_x));
    check_field("out_y", 32'(want.key.y), 32'(out_mon.out_y));
    check_field("out_z", 32'(want.key.z), 32'(out_mon.out_z));
    check_field("out_charge", 32'(want.charge), 32'(out_mon.out_charge));
    check_field("last_entry", 32'(want.last_entry), 32'(out_mon.last_entry));
    check_field("dropped_hits", 32'(want.dropped_hits), 32'(out_mon.dropped_hits));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      n_entries     = 0;
      overflow_flag = 1'b0;
      merged_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.mode) begin
          flush_event();
        end else begin
          absorb_hit(key_t'{in_mon.hit_view, in_mon.hit_x, in_mon.hit_y, in_mon.hit_z},
                     longint'(in_mon.hit_charge));
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        check_entry();
      end
    end
    pending_count <= merged_q.size();
  end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import hmk_pkg::*;

  localparam int MAX_ENTRIES  = 64;
  localparam int SUM_BITS     = 24;
  localparam int RANDOM_HITS  = 16;
  // a hit scan is bounded by the table size and gaps are bounded too,
  // so a quiet stretch of this length means the block has hung
  localparam int STALL_LIMIT  = 2000;
  // room for every emitted entry to be read and loaded, plus slack for the output register
  localparam int DRAIN_CYCLES = 2 * MAX_ENTRIES + 16;

  logic clk;
  logic rst_n;

  hmk_in_if  in_chan();
  hmk_out_if out_chan();

  int   error_count;
  int   pending_count;
  int   entries_checked;
  int   hits_sent;
  int   events_sent;
  int   idle_cycles;
  bit   calm;          // no gaps on either side while set
  key_t event_keys[$]; // keys sent in the current event, for repeats

  hit_merge_by_key_accumulate #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .SUM_BITS   (SUM_BITS)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  hmk_merge_checker #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .SUM_BITS   (SUM_BITS)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .error_count    (error_count),
    .pending_count  (pending_count),
    .entries_checked(entries_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap lengths: mostly none or short, now and then a long one
  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic key_t random_key();
    key_t k;
    k.view = VIEW_W'($urandom_range(0, 3));
    k.x    = COORD_W'($urandom_range(0, 255));
    k.y    = COORD_W'($urandom_range(0, 255));
    k.z    = COORD_W'($urandom_range(0, 255));
    return k;
  endfunction

  // charge extremes turn up often enough to matter
  function automatic logic [CHARGE_W-1:0] random_charge();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return CHARGE_W'($urandom_range(0, 16'hFFFF));
  endfunction

  // half the time a key already seen in this event, so merges are frequent
  function automatic key_t pick_key();
    if (event_keys.size() > 0 && $urandom_range(0, 1) == 1)
      return event_keys[$urandom_range(0, event_keys.size() - 1)];
    return random_key();
  endfunction

  // one transfer on the input channel, after a random gap;
  // ready is looked at on the falling edge, where it is settled
  task automatic send_item(input logic mode, input key_t key,
                           input logic [CHARGE_W-1:0] charge);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.mode       <= mode;
    in_chan.hit_view   <= key.view;
    in_chan.hit_x      <= key.x;
    in_chan.hit_y      <= key.y;
    in_chan.hit_z      <= key.z;
    in_chan.hit_charge <= charge;
    do @(negedge clk); while (in_chan.ready !== 1'b1);
    @(posedge clk);
    if (mode) events_sent++;
    else hits_sent++;
  endtask

  task automatic hit(input key_t key, input logic [CHARGE_W-1:0] charge);
    send_item(1'b0, key, charge);
    event_keys = {event_keys, key};
  endtask

  // key and charge fields carry noise here, the block must ignore them
  task automatic end_event();
    send_item(1'b1, random_key(), CHARGE_W'($urandom_range(0, 16'hFFFF)));
    event_keys.delete();
  endtask

  // n_new distinct keys (x tells them apart); past the table size the extra
  // keys are dropped, while repeats of stored keys must still merge
  task automatic fill_table(input int n_new);
    key_t k;
    for (int i = 0; i < n_new; i++) begin
      k   = random_key();
      k.x = 8'(i);
      hit(k, random_charge());
      if (i >= MAX_ENTRIES - 2 && $urandom_range(0, 1) == 1)
        hit(event_keys[$urandom_range(0, MAX_ENTRIES - 3)], random_charge());
    end
    end_event();
  endtask

  // result side: ready held high for a while, then dropped for a gap
  initial begin
    int stall;
    out_chan.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = gap_len();
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // watchdog: cycles without a transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog, no transfer for %0d cycles", $time, idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int random_hits;
    int n_hits;

    calm               = 1'b0;
    hits_sent          = 0;
    events_sent        = 0;
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.mode       <= 1'b0;
    in_chan.hit_view   <= '0;
    in_chan.hit_x      <= '0;
    in_chan.hit_y      <= '0;
    in_chan.hit_z      <= '0;
    in_chan.hit_charge <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty event straight after reset: no entries
    end_event();

    // key extremes, keys that differ in one field only, charge extremes
    hit(key_t'{2'd0, 8'd0, 8'd0, 8'd0}, 16'h0000);
    hit(key_t'{2'd3, 8'd255, 8'd255, 8'd255}, 16'hFFFF);
    hit(key_t'{2'd3, 8'd255, 8'd255, 8'd255}, 16'hFFFF);
    hit(key_t'{2'd2, 8'd255, 8'd255, 8'd255}, 16'h0001);
    hit(key_t'{2'd3, 8'd255, 8'd255, 8'd254}, 16'h8000);
    hit(key_t'{2'd0, 8'd0, 8'd0, 8'd0}, 16'h0001);
    end_event();

    // single entry, which is also the last
    hit(key_t'{2'd1, 8'h55, 8'hAA, 8'h0F}, 16'h5A5A);
    end_event();

    // empty event after a full one
    end_event();

    // one key hit back to back, another in between
    hit(key_t'{2'd2, 8'hAA, 8'h55, 8'hF0}, 16'hA5A5);
    hit(key_t'{2'd2, 8'hAA, 8'h55, 8'hF0}, 16'h1234);
    hit(key_t'{2'd1, 8'hAA, 8'h55, 8'hF0}, 16'h00FF);
    hit(key_t'{2'd2, 8'hAA, 8'h55, 8'hF0}, 16'hFF00);
    end_event();

    // table filled to the last entry, then two more new keys dropped
    fill_table(MAX_ENTRIES + 2);

    // short random events
    random_hits = 0;
    while (random_hits < RANDOM_HITS) begin
      calm   = ($urandom_range(0, 4) == 0);
      n_hits = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      repeat (n_hits) hit(pick_key(), random_charge());
      end_event();
      random_hits += n_hits;
    end

    // let the checker see the last transfer, then wait for every entry
    calm = 1'b0;
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d hits and %0d end-of-event transfers sent, %0d entries checked",
             hits_sent, events_sent, entries_checked);
    $display("summary: empty events, a full table with dropped keys, repeats and charge extremes");
    if (error_count == 0 && pending_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
